### rtl/rmcc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the
// record magic/CRC checker. No dependencies.
package rmcc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_DATA_W-1:0] MAGIC_RESET = 32'h55AA55AA;
   localparam logic [15:0]           CRC_INIT    = 16'hFFFF;
   localparam logic [15:0]           CRC_POLY    = 16'hA001;
   localparam logic [15:0]           CRC_LSB     = 16'h0001;

   // register index of magic_word, taken from paddr word bits
   localparam logic CSR_IDX_MAGIC = 1'b0;

   // record status codes
   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_MAGIC = 2'd1;
   localparam logic [1:0] ST_CRC   = 2'd2;
   localparam logic [1:0] ST_SHORT = 2'd3;

   // what a command ends with
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_CRC    = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // one command from front to back: up to one data byte, then an ending, if any
   typedef struct packed {
      logic        has_data;
      logic [7:0]  data;
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [15:0] crc;
   } cmd_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
      logic [15:0] c;
      c = crc_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_LSB) != 16'h0000) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/rmcc_if.sv
// Valid/ready channel interfaces for the record checker's byte input
// and result output. Depends on nothing.
interface rmcc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_in;
   logic       last_in;

   modport source (output valid, output op, output data_in, output last_in, input ready);
   modport sink   (input valid, input op, input data_in, input last_in, output ready);
endinterface

interface rmcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       is_status;
   logic [1:0] status;
   logic       last_out;

   modport source (output valid, output data_out, output is_status, output status,
                   output last_out, input ready);
   modport sink   (input valid, input data_out, input is_status, input status,
                   input last_out, output ready);
endinterface

### rtl/rmcc_front.sv
// Front end: accepts record bytes, checks/inserts magic, runs the CRC and
// the two-byte delay, and pushes commands. Uses rmcc_pkg and rmcc_req_if.
module rmcc_front #(
   parameter int MAGIC_BYTES = 4
) (
   input  logic                clock,
   input  logic                reset,
   rmcc_req_if.sink            req_chan,
   input  logic [31:0]         magic_word,
   input  logic                q_full,
   output logic                q_push,
   output rmcc_pkg::cmd_type   q_cmd
);
   import rmcc_pkg::*;

   localparam int MIN_RECORD = MAGIC_BYTES + 2;
   localparam int CNT_W      = $clog2(MIN_RECORD + 1);

   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       held0_ff, held0_in, held1_ff, held1_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             magic_good_ff, magic_good_in;
   logic             mode_ff, mode_in;

   logic             accept;
   logic             mode;
   logic [3:0]       pos_w;
   logic [7:0]       magic_b;
   logic             in_magic;
   logic [7:0]       b;
   logic             magic_miss;
   logic             past_two;
   logic [15:0]      crc_next;
   logic [CNT_W-1:0] count_inc;
   logic             short_rec;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;

   always_comb begin
      mode  = (count_ff == '0) ? req_chan.op : mode_ff;
      pos_w = 4'(count_ff);
      case (pos_w)
         4'd0:    magic_b = magic_word[7:0];
         4'd1:    magic_b = magic_word[15:8];
         4'd2:    magic_b = magic_word[23:16];
         4'd3:    magic_b = magic_word[31:24];
         default: magic_b = 8'h00;
      endcase
      in_magic   = count_ff < CNT_W'(MAGIC_BYTES);
      b          = (in_magic && mode) ? magic_b : req_chan.data_in;
      magic_miss = in_magic && !mode && (req_chan.data_in != magic_b);
      past_two   = count_ff >= CNT_W'(2);
      crc_next   = past_two ? crc_feed(crc_ff, held0_ff) : crc_ff;
      count_inc  = (count_ff < CNT_W'(MIN_RECORD)) ? count_ff + CNT_W'(1) : count_ff;
      short_rec  = count_inc < CNT_W'(MIN_RECORD);

      q_cmd.has_data = mode && past_two;
      q_cmd.data     = held0_ff;
      q_cmd.crc      = crc_next;
      if (!req_chan.last_in) begin
         q_cmd.kind = KIND_NONE;
      end else if (short_rec || !mode) begin
         q_cmd.kind = KIND_STATUS;
      end else begin
         q_cmd.kind = KIND_CRC;
      end
      // received CRC: low byte in the delay line, high byte is the current byte
      if (short_rec) begin
         q_cmd.status = ST_SHORT;
      end else if (!magic_good_ff || magic_miss) begin
         q_cmd.status = ST_MAGIC;
      end else if ({b, held1_ff} != crc_next) begin
         q_cmd.status = ST_CRC;
      end else begin
         q_cmd.status = ST_VALID;
      end
      q_push = accept && ((mode && past_two) || req_chan.last_in);

      crc_in        = crc_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      count_in      = count_ff;
      magic_good_in = magic_good_ff;
      mode_in       = mode_ff;
      if (accept) begin
         if (req_chan.last_in) begin
            crc_in        = CRC_INIT;
            held0_in      = 8'h00;
            held1_in      = 8'h00;
            count_in      = '0;
            magic_good_in = 1'b1;
            mode_in       = 1'b0;
         end else begin
            crc_in        = crc_next;
            held0_in      = held1_ff;
            held1_in      = b;
            count_in      = count_inc;
            magic_good_in = magic_good_ff && !magic_miss;
            mode_in       = mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= CRC_INIT;
         held0_ff      <= 8'h00;
         held1_ff      <= 8'h00;
         count_ff      <= '0;
         magic_good_ff <= 1'b1;
         mode_ff       <= 1'b0;
      end else begin
         crc_ff        <= crc_in;
         held0_ff      <= held0_in;
         held1_ff      <= held1_in;
         count_ff      <= count_in;
         magic_good_ff <= magic_good_in;
         mode_ff       <= mode_in;
      end
   end

endmodule

### rtl/rmcc_queue.sv
// Small command queue between front and back ends.
// Uses rmcc_pkg for the command type and depth.
module rmcc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rmcc_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output rmcc_pkg::cmd_type   head,
   output logic                full,
   output logic                empty
);
   import rmcc_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;

   assign full  = fill_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign empty = fill_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (QUEUE_PTR_W + 1)'(push) - (QUEUE_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/rmcc_back.sv
// Back end: expands each queued command into result items (data byte,
// status or CRC bytes) through an output register. Uses rmcc_pkg, rmcc_rsp_if.
module rmcc_back (
   input  logic                clock,
   input  logic                reset,
   input  rmcc_pkg::cmd_type   head,
   input  logic                q_empty,
   output logic                q_pop,
   rmcc_rsp_if.source          rsp_chan
);
   import rmcc_pkg::*;

   localparam logic [1:0] PH_DATA = 2'd0;
   localparam logic [1:0] PH_END1 = 2'd1;
   localparam logic [1:0] PH_END2 = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] data_ff, data_in;
   logic       is_status_ff, is_status_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;

   logic       load;
   logic       final_item;
   logic [1:0] eff_phase;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.data_out  = data_ff;
   assign rsp_chan.is_status = is_status_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.last_out  = last_ff;

   always_comb begin
      load      = !q_empty && (!out_valid_ff || rsp_chan.ready);
      eff_phase = (phase_ff == PH_DATA && !head.has_data) ? PH_END1 : phase_ff;

      data_in      = 8'h00;
      is_status_in = 1'b0;
      status_in    = ST_VALID;
      last_in      = 1'b0;
      final_item   = 1'b1;
      case (eff_phase)
         PH_DATA: begin
            data_in    = head.data;
            final_item = head.kind == KIND_NONE;
         end
         PH_END1: begin
            if (head.kind == KIND_STATUS) begin
               is_status_in = 1'b1;
               status_in    = head.status;
               last_in      = 1'b1;
            end else begin
               data_in    = head.crc[7:0];
               final_item = 1'b0;
            end
         end
         PH_END2: begin
            data_in = head.crc[15:8];
            last_in = 1'b1;
         end
         default: begin
            final_item = 1'b1;
         end
      endcase

      q_pop = load && final_item;
      if (!load) begin
         phase_in = phase_ff;
      end else if (final_item) begin
         phase_in = PH_DATA;
      end else begin
         phase_in = eff_phase + 2'd1;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DATA;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff      <= data_in;
         is_status_ff <= is_status_in;
         status_ff    <= status_in;
         last_ff      <= last_in;
      end
   end

   // a command stays at the head until its final item is loaded into the output register
   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_DATA |-> !q_empty)
      else $error("command popped mid-expansion");

   a_phase_crc: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_END2 |-> head.kind == KIND_CRC)
      else $error("CRC high byte phase on a non-CRC command");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("illegal expansion phase");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && is_status_ff |-> last_ff && data_ff == 8'h00)
      else $error("status item not closing its record");

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !is_status_ff |-> status_ff == ST_VALID)
      else $error("data item carries a status code");

endmodule

### rtl/record_magic_crc_checker.sv
// Record magic/CRC checker top level: magic_word register on the APB-style
// port plus front end, command queue and back end. Uses rmcc_pkg, rmcc_if.
//
// Takes one record byte per cycle when the result side keeps up. Every byte
// is handled by the front end's combinational logic (the unrolled 8-bit CRC
// update is the long path); each result item leaves through the back end's
// output register at one per cycle while rsp ready holds. A sealed record of
// N bytes gives N result items for N input bytes, so its last byte expands
// into three items, which the four-entry command queue absorbs; a verified
// record gives one status item. No reset sweep: items are taken once reset drops.
module record_magic_crc_checker #(
   parameter int MAGIC_BYTES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   rmcc_req_if.sink                            req_chan,
   rmcc_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rmcc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rmcc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rmcc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import rmcc_pkg::*;

   logic [CSR_DATA_W-1:0] magic_ff, magic_in;
   logic                  magic_sel;

   cmd_type q_cmd;
   cmd_type q_head;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   assign pready    = 1'b1;
   assign magic_sel = paddr[2] == CSR_IDX_MAGIC;
   assign prdata    = magic_sel ? magic_ff : '0;

   always_comb begin
      magic_in = magic_ff;
      if (psel && penable && pwrite && magic_sel) begin
         magic_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else begin
         magic_ff <= magic_in;
      end
   end

   rmcc_front #(
      .MAGIC_BYTES (MAGIC_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .magic_word (magic_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   rmcc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   rmcc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
